/* hdl/websocket_frame_decoder_assert.svh */
// Assertion macros used by the frame decoder checker.
`ifndef WEBSOCKET_FRAME_DECODER_ASSERT_SVH
`define WEBSOCKET_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/wfd_pkg.sv */
// Shared types and codes of the WebSocket frame decoder.
`timescale 1ns / 1ps

package wfd_pkg;

    localparam int TDATA_W = 16;

    localparam logic       KIND_PAYLOAD = 1'b0;
    localparam logic       KIND_STATUS  = 1'b1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT  = 3'd1;
    localparam logic [2:0] ST_CLOSE      = 3'd2;
    localparam logic [2:0] ST_UNSUP      = 3'd3;
    localparam logic [2:0] ST_HDR_TRUNC  = 3'd4;
    localparam logic [2:0] ST_PAY_TRUNC  = 3'd5;

    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] MASK_BYTES  = 4'd4;

    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic [2:0] status;
    } result_t;

endpackage

/* hdl/websocket_frame_decoder.sv */
// Top level of the WebSocket frame decoder: header parse, unmask and result queue.
`timescale 1ns / 1ps
//
// Usage:
//   s_* channel: one raw frame buffer byte per beat in s_tdata[7:0]; s_tlast
//   marks the last byte of the buffer, which holds exactly one frame.
//   m_* channel: one result per beat. m_tuser 0 is an unmasked text payload
//   byte in m_tdata[7:0]; m_tuser 1 is the end-of-buffer status in
//   m_tdata[10:8] (ok, too short, close, unsupported opcode, header
//   truncated, payload truncated). On an error status drop the bytes seen.
//   Results are registered in the queue before they show on m_*.
//   Throughput: one input byte per cycle while s_tready is high; the header
//   parser and unmask XOR are combinational. A last byte that also carries
//   payload yields two results, so the output takes a beat for each. Results
//   wait in a 4-entry queue; s_tready drops while fewer than two entries are free.
//   Reset: the parser waits for the first header byte and the queue empties.
//   A stalled receiver holds m_* steady and fills the queue, then s_tready
//   falls until entries drain.

module websocket_frame_decoder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] frame_byte
    input  logic                        s_tlast,   // buffer_end
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [wfd_pkg::TDATA_W-1:0] m_tdata,   // [7:0] payload_byte, [10:8] frame_status
    output logic                        m_tuser    // result_kind
);

    localparam int FIFO_DEPTH = wfd_pkg::FIFO_DEPTH;
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0] ACCEPT_MAX = CNT_W'(FIFO_DEPTH - 2);

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXTLEN,
        PH_MASK,
        PH_PAYLOAD,
        PH_DONE,
        PH_CLOSE,
        PH_UNSUP
    } phase_t;

    function automatic logic [2:0] end_status(input phase_t ph);
        logic [2:0] st;
        case (ph)
            PH_HDR0:    st = wfd_pkg::ST_TOO_SHORT;
            PH_HDR1:    st = wfd_pkg::ST_TOO_SHORT;
            PH_EXTLEN:  st = wfd_pkg::ST_HDR_TRUNC;
            PH_MASK:    st = wfd_pkg::ST_HDR_TRUNC;
            PH_PAYLOAD: st = wfd_pkg::ST_PAY_TRUNC;
            PH_DONE:    st = wfd_pkg::ST_OK;
            PH_CLOSE:   st = wfd_pkg::ST_CLOSE;
            PH_UNSUP:   st = wfd_pkg::ST_UNSUP;
            default:    st = wfd_pkg::ST_OK;
        endcase
        return st;
    endfunction

    phase_t      phase_reg, phase_next;
    logic [3:0]  hcount_reg, hcount_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        mask_reg, mask_next;
    logic [63:0] length_reg, length_next;
    logic [31:0] key_reg, key_next;
    logic [63:0] remain_reg, remain_next;
    logic [1:0]  kidx_reg, kidx_next;

    wfd_pkg::result_t fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             accept;
    logic             pop;
    logic             pay_emit;
    logic             stat_emit;
    logic [7:0]       pay_byte;
    logic [7:0]       key_byte;
    logic [6:0]       len7;
    logic [63:0]      len_shift;
    logic [63:0]      len_sel;
    logic             len_ready;
    logic             start_pay;
    logic [3:0]       hcount_dec;
    wfd_pkg::result_t first_ent;
    wfd_pkg::result_t second_ent;
    wfd_pkg::result_t head_ent;

    assign s_tready = (count_reg <= ACCEPT_MAX);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != '0);
    assign pop      = m_tvalid && m_tready;

    assign len7       = s_tdata[6:0];
    assign len_shift  = {length_reg[55:0], s_tdata};
    assign hcount_dec = hcount_reg - 4'd1;

    always_comb
    begin
        case (kidx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    assign pay_byte = s_tdata ^ key_byte;

    always_comb
    begin
        phase_next  = phase_reg;
        hcount_next = hcount_reg;
        opcode_next = opcode_reg;
        mask_next   = mask_reg;
        length_next = length_reg;
        key_next    = key_reg;
        remain_next = remain_reg;
        kidx_next   = kidx_reg;
        pay_emit    = 1'b0;
        len_ready   = 1'b0;
        start_pay   = 1'b0;
        len_sel     = length_reg;

        case (phase_reg)
            PH_HDR0:
            begin
                opcode_next = s_tdata[3:0];
                phase_next  = PH_HDR1;
            end
            PH_HDR1:
            begin
                mask_next = s_tdata[7];
                if (opcode_reg == wfd_pkg::OP_CLOSE)
                begin
                    phase_next = PH_CLOSE;
                end
                else if (opcode_reg != wfd_pkg::OP_TEXT)
                begin
                    phase_next = PH_UNSUP;
                end
                else if (len7 == wfd_pkg::LEN_EXT16 || len7 == wfd_pkg::LEN_EXT64)
                begin
                    length_next = '0;
                    hcount_next = (len7 == wfd_pkg::LEN_EXT16) ?
                                  wfd_pkg::EXT16_BYTES : wfd_pkg::EXT64_BYTES;
                    phase_next  = PH_EXTLEN;
                end
                else
                begin
                    len_sel     = {57'd0, len7};
                    length_next = len_sel;
                    len_ready   = 1'b1;
                end
            end
            PH_EXTLEN:
            begin
                len_sel     = len_shift;
                length_next = len_sel;
                hcount_next = hcount_dec;
                len_ready   = (hcount_dec == 4'd0);
            end
            PH_MASK:
            begin
                key_next    = {key_reg[23:0], s_tdata};
                hcount_next = hcount_dec;
                start_pay   = (hcount_dec == 4'd0);
            end
            PH_PAYLOAD:
            begin
                pay_emit    = 1'b1;
                kidx_next   = kidx_reg + 2'd1;
                remain_next = remain_reg - 64'd1;
                if (remain_reg == 64'd1)
                begin
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
            end
        endcase

        if (len_ready)
        begin
            if (mask_next)
            begin
                hcount_next = wfd_pkg::MASK_BYTES;
                phase_next  = PH_MASK;
            end
            else
            begin
                start_pay = 1'b1;
            end
        end

        if (start_pay)
        begin
            remain_next = len_sel;
            kidx_next   = 2'd0;
            phase_next  = (len_sel == 64'd0) ? PH_DONE : PH_PAYLOAD;
        end

        stat_emit             = s_tlast;
        second_ent.kind       = wfd_pkg::KIND_STATUS;
        second_ent.data       = 8'd0;
        second_ent.status     = end_status(phase_next);

        if (s_tlast)
        begin
            phase_next  = PH_HDR0;
            hcount_next = 4'd0;
            opcode_next = 4'd0;
            mask_next   = 1'b0;
            length_next = '0;
            key_next    = '0;
            remain_next = '0;
            kidx_next   = 2'd0;
        end

        if (pay_emit)
        begin
            first_ent.kind   = wfd_pkg::KIND_PAYLOAD;
            first_ent.data   = pay_byte;
            first_ent.status = wfd_pkg::ST_OK;
        end
        else
        begin
            first_ent = second_ent;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
        begin
            if (pay_emit && stat_emit)
            begin
                wr_ptr_next = wr_ptr_reg + PTR_W'(2);
                count_next  = count_next + CNT_W'(2);
            end
            else if (pay_emit || stat_emit)
            begin
                wr_ptr_next = wr_ptr_reg + PTR_W'(1);
                count_next  = count_next + CNT_W'(1);
            end
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
            count_next  = count_next - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            hcount_reg <= 4'd0;
            opcode_reg <= 4'd0;
            mask_reg   <= 1'b0;
            length_reg <= '0;
            key_reg    <= '0;
            remain_reg <= '0;
            kidx_reg   <= 2'd0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg  <= phase_next;
                hcount_reg <= hcount_next;
                opcode_reg <= opcode_next;
                mask_reg   <= mask_next;
                length_reg <= length_next;
                key_reg    <= key_next;
                remain_reg <= remain_next;
                kidx_reg   <= kidx_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (pay_emit || stat_emit))
        begin
            fifo_mem[wr_ptr_reg] <= first_ent;
        end
        if (accept && pay_emit && stat_emit)
        begin
            fifo_mem[wr_ptr_reg + PTR_W'(1)] <= second_ent;
        end
    end

    assign head_ent = fifo_mem[rd_ptr_reg];
    assign m_tuser  = head_ent.kind;
    assign m_tdata  = {{(wfd_pkg::TDATA_W - 11){1'b0}}, head_ent.status, head_ent.data};

endmodule

/* hdl/wfd_checker.sv */
// Port-level assertions for the WebSocket frame decoder, bound to the top level.
`timescale 1ns / 1ps
`include "websocket_frame_decoder_assert.svh"

module wfd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [7:0]                  s_tdata,
    input logic                        s_tlast,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [wfd_pkg::TDATA_W-1:0] m_tdata,
    input logic                        m_tuser
);

    logic status_beat;
    logic payload_beat;

    assign status_beat  = m_tvalid && (m_tuser == wfd_pkg::KIND_STATUS);
    assign payload_beat = m_tvalid && (m_tuser == wfd_pkg::KIND_PAYLOAD);

    `WFD_ASSERT_NOW(a_status_no_data, clk, rst_n, status_beat, m_tdata[7:0] == 8'd0,
        "status beat carries payload bits")
    `WFD_ASSERT_NOW(a_payload_no_status, clk, rst_n, payload_beat,
        m_tdata[10:8] == wfd_pkg::ST_OK, "payload beat carries status bits")
    `WFD_ASSERT_NOW(a_status_code, clk, rst_n, status_beat,
        m_tdata[10:8] <= wfd_pkg::ST_PAY_TRUNC, "status code out of range")
    `WFD_ASSERT_NEXT(a_stall_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind websocket_frame_decoder wfd_checker u_wfd_checker (.*);
